/* hdl/lkec_pkg.sv */
// Package for the LRU keyed entry cache: sizes, field widths, op codes,
// the stored entry layout and the tag memory request bundle.
// Depends on nothing; every other file of the block but lkec_ram refers to it.
package lkec_pkg;

    // Table size and the widths that follow from it
    localparam int CAPACITY = 96;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Fixed field widths of the item formats
    localparam int TEXT_LO_W  = 64;
    localparam int TEXT_HI_W  = 56;
    localparam int TEXT_BYTES = 15;
    localparam int SIZE_W     = 10;
    localparam int COLOR_W    = 32;
    localparam int STAMP_W    = 32;
    localparam int SLOT_W     = 7;
    localparam int COUNT_W    = 7;

    // Operation codes
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    // One stored entry: key plus use stamp
    typedef struct packed {
        logic [TEXT_LO_W-1:0] text_lo;
        logic [TEXT_HI_W-1:0] text_hi;
        logic [SIZE_W-1:0]    size;
        logic [COLOR_W-1:0]   color;
        logic [STAMP_W-1:0]   stamp;
    } t_entry;

    // Access request from the sequencer to the tag memory
    typedef struct packed {
        logic             re;
        logic [IDX_W-1:0] raddr;
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_entry           wdata;
    } t_ram_req;

endpackage

/* hdl/lkec_ifs.sv */
// Valid/ready channel interfaces of the LRU keyed entry cache.
// Depends on lkec_pkg for field widths.

interface lkec_in_if;
    logic                            valid;
    logic                            ready;
    logic                            op;
    logic [lkec_pkg::TEXT_LO_W-1:0]  text_bytes_lo;
    logic [lkec_pkg::TEXT_HI_W-1:0]  text_bytes_hi;
    logic                            text_too_long;
    logic [lkec_pkg::SIZE_W-1:0]     pixel_size;
    logic [lkec_pkg::COLOR_W-1:0]    pixel_color;

    modport source (output valid, op, text_bytes_lo, text_bytes_hi, text_too_long,
                     pixel_size, pixel_color, input ready);
    modport sink   (input valid, op, text_bytes_lo, text_bytes_hi, text_too_long,
                     pixel_size, pixel_color, output ready);
endinterface

interface lkec_out_if;
    logic                          valid;
    logic                          ready;
    logic                          hit;
    logic [lkec_pkg::SLOT_W-1:0]   slot;
    logic                          evicts;
    logic [lkec_pkg::COUNT_W-1:0]  entries_in_use;

    modport source (output valid, hit, slot, evicts, entries_in_use, input ready);
    modport sink   (input valid, hit, slot, evicts, entries_in_use, output ready);
endinterface

/* hdl/lkec_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. Depends on nothing.
module lkec_ram #(
    parameter int DEPTH = 96,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port with registered read data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

/* hdl/lkec_ctrl.sv */
// Sequencer of the LRU keyed entry cache: key cleanup, table walk with
// compare and oldest-stamp search, write-back, fill count, tick and result.
// Depends on lkec_pkg and the channel interfaces in lkec_ifs.
module lkec_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    lkec_in_if.sink             i_in,
    lkec_out_if.source          o_out,
    output lkec_pkg::t_ram_req  o_ram_req,
    input  lkec_pkg::t_entry    i_ram_rdata
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_WRITE = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]                     r_state;
    logic [lkec_pkg::CNT_W-1:0]     r_fill;
    logic [lkec_pkg::STAMP_W-1:0]   r_tick;

    logic [lkec_pkg::TEXT_LO_W-1:0] r_key_lo;
    logic [lkec_pkg::TEXT_HI_W-1:0] r_key_hi;
    logic [lkec_pkg::SIZE_W-1:0]    r_key_size;
    logic [lkec_pkg::COLOR_W-1:0]   r_key_rgba;
    logic                           r_too_long;

    logic [lkec_pkg::CNT_W-1:0]     r_issue;
    logic                           r_dv;
    logic [lkec_pkg::IDX_W-1:0]     r_didx;
    logic                           r_hit;
    logic [lkec_pkg::IDX_W-1:0]     r_slot;
    logic                           r_evicts;
    logic                           r_min_vld;
    logic [lkec_pkg::STAMP_W-1:0]   r_min_stamp;
    logic [lkec_pkg::IDX_W-1:0]     r_min_idx;

    logic                           r_out_vld;
    logic                           r_out_hit;
    logic [lkec_pkg::SLOT_W-1:0]    r_out_slot;
    logic                           r_out_evicts;
    logic [lkec_pkg::COUNT_W-1:0]   r_out_cnt;

    logic [lkec_pkg::TEXT_LO_W+lkec_pkg::TEXT_HI_W-1:0] clean_txt;
    logic                           txt_ended;
    logic                           rd_en;
    logic                           key_match;
    logic                           table_full;
    logic [lkec_pkg::IDX_W-1:0]     wr_slot;
    logic                           out_free;

    // Zero every byte after the first zero byte of the incoming string
    always_comb begin
        clean_txt = {i_in.text_bytes_hi, i_in.text_bytes_lo};
        txt_ended = 1'b0;
        for (int b = 0; b < lkec_pkg::TEXT_BYTES; b++) begin
            if (txt_ended) begin
                clean_txt[b*8 +: 8] = 8'd0;
            end else if (clean_txt[b*8 +: 8] == 8'd0) begin
                txt_ended = 1'b1;
            end
        end
    end

    // Walk the filled entries one read per cycle
    assign rd_en = (r_state == S_SCAN) && (r_issue < r_fill);

    assign key_match = !r_too_long
                    && (i_ram_rdata.text_lo == r_key_lo)
                    && (i_ram_rdata.text_hi == r_key_hi)
                    && (i_ram_rdata.size    == r_key_size)
                    && (i_ram_rdata.color   == r_key_rgba);

    // Pick the entry to write: the hit, the next free one or the oldest
    assign table_full = (r_fill == lkec_pkg::CNT_W'(lkec_pkg::CAPACITY));
    assign wr_slot    = r_hit      ? r_slot :
                        table_full ? r_min_idx : r_fill[lkec_pkg::IDX_W-1:0];

    always_comb begin
        o_ram_req               = '0;
        o_ram_req.re            = rd_en;
        o_ram_req.raddr         = r_issue[lkec_pkg::IDX_W-1:0];
        o_ram_req.we            = (r_state == S_WRITE);
        o_ram_req.waddr         = wr_slot;
        o_ram_req.wdata.text_lo = r_key_lo;
        o_ram_req.wdata.text_hi = r_key_hi;
        o_ram_req.wdata.size    = r_key_size;
        o_ram_req.wdata.color   = r_key_rgba;
        o_ram_req.wdata.stamp   = r_tick + 1'b1;
    end

    assign out_free = !r_out_vld || o_out.ready;

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_tick  <= '0;
            r_dv    <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_key_lo    <= clean_txt[lkec_pkg::TEXT_LO_W-1:0];
                        r_key_hi    <= clean_txt[lkec_pkg::TEXT_LO_W +: lkec_pkg::TEXT_HI_W];
                        r_key_size  <= i_in.pixel_size;
                        r_key_rgba  <= i_in.pixel_color;
                        r_too_long  <= i_in.text_too_long;
                        r_issue     <= '0;
                        r_dv        <= 1'b0;
                        r_hit       <= 1'b0;
                        r_slot      <= '0;
                        r_evicts    <= 1'b0;
                        r_min_vld   <= 1'b0;
                        if (i_in.op == lkec_pkg::OP_FLUSH) begin
                            r_fill  <= '0;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    // drop the data in flight once a match ends the walk
                    r_dv   <= rd_en && !(r_dv && key_match);
                    r_didx <= r_issue[lkec_pkg::IDX_W-1:0];
                    if (rd_en) begin
                        r_issue <= r_issue + 1'b1;
                    end
                    if (r_dv) begin
                        if (key_match) begin
                            // stop at the first matching entry
                            r_hit   <= 1'b1;
                            r_slot  <= r_didx;
                            r_state <= S_WRITE;
                        end else if (!r_min_vld || (i_ram_rdata.stamp < r_min_stamp)) begin
                            // strict compare keeps the lowest index on a tie
                            r_min_vld   <= 1'b1;
                            r_min_stamp <= i_ram_rdata.stamp;
                            r_min_idx   <= r_didx;
                        end
                    end else if (!rd_en) begin
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    r_tick <= r_tick + 1'b1;
                    r_slot <= wr_slot;
                    if (!r_hit) begin
                        if (table_full) begin
                            r_evicts <= 1'b1;
                        end else begin
                            r_fill <= r_fill + 1'b1;
                        end
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Output register: load the result, hold it until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if ((r_state == S_DONE) && out_free) begin
            r_out_vld    <= 1'b1;
            r_out_hit    <= r_hit;
            r_out_slot   <= lkec_pkg::SLOT_W'(r_slot);
            r_out_evicts <= r_evicts;
            r_out_cnt    <= lkec_pkg::COUNT_W'(r_fill);
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    assign i_in.ready           = (r_state == S_IDLE);
    assign o_out.valid          = r_out_vld;
    assign o_out.hit            = r_out_hit;
    assign o_out.slot           = r_out_slot;
    assign o_out.evicts         = r_out_evicts;
    assign o_out.entries_in_use = r_out_cnt;

endmodule

/* hdl/lru_keyed_entry_cache.sv */
// Channel    | Dir | Payload
// i_in       | in  | op, text_bytes_lo, text_bytes_hi, text_too_long, pixel_size, pixel_color
// o_out      | out | hit, slot, evicts, entries_in_use
//
// A lookup walks at most the filled entries of the table: the sequencer
// reads one table entry per cycle from the tag memory read port, so a
// full table means a walk over all 96 entries. A hit ends the walk early.
// A flush skips the walk. Reset empties the table and zeroes the tick;
// the memory contents are not cleared. A result waits in an output
// register, and the next item is accepted meanwhile; while that register is
// still full, a finished item holds the sequencer until the result is taken.
//
// Top level of the LRU keyed entry cache: sequencer plus tag memory.
// Depends on lkec_pkg, lkec_ifs, lkec_ram and lkec_ctrl.
module lru_keyed_entry_cache (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lkec_in_if.sink     i_in,
    lkec_out_if.source  o_out
);

    lkec_pkg::t_ram_req ram_req;
    lkec_pkg::t_entry   ram_rdata;

    lkec_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_out       (o_out),
        .o_ram_req   (ram_req),
        .i_ram_rdata (ram_rdata)
    );

    lkec_ram #(
        .DEPTH (lkec_pkg::CAPACITY),
        .WIDTH ($bits(lkec_pkg::t_entry))
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    // One item at a time: no accept right after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("item accepted while previous item in work");

    // A hit never evicts
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.hit) |-> !o_out.evicts)
        else $error("hit result reports eviction");

    // Eviction only from a full table
    a_evict_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.evicts) |->
            (o_out.entries_in_use == lkec_pkg::COUNT_W'(lkec_pkg::CAPACITY)))
        else $error("eviction with free entries left");

    // A hit result always reports at least one entry filled
    a_lookup_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.hit) |-> (o_out.entries_in_use != '0))
        else $error("hit on an empty table");

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for the LRU keyed entry cache: directed key cases, then
// random lookups and flushes over key pools, checked against an in-bench LRU table.
// Depends on lkec_pkg, lkec_ifs and the lru_keyed_entry_cache top level.
module tb;

    localparam int TEXT_W = lkec_pkg::TEXT_LO_W + lkec_pkg::TEXT_HI_W;
    localparam int POOL_MAX = 256;

    // One lookup or flush request as driven on the input channel
    typedef struct packed {
        logic                           op;
        logic [lkec_pkg::TEXT_LO_W-1:0] text_lo;
        logic [lkec_pkg::TEXT_HI_W-1:0] text_hi;
        logic                           too_long;
        logic [lkec_pkg::SIZE_W-1:0]    size;
        logic [lkec_pkg::COLOR_W-1:0]   color;
    } t_lookup_req;

    // One result as seen on the output channel
    typedef struct packed {
        logic                         hit;
        logic [lkec_pkg::SLOT_W-1:0]  slot;
        logic                         evicts;
        logic [lkec_pkg::COUNT_W-1:0] in_use;
    } t_lookup_rsp;

    logic i_clk;
    logic i_rst_n;

    lkec_in_if  in_ch ();
    lkec_out_if out_ch ();

    lru_keyed_entry_cache dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Shadow LRU table
    logic [TEXT_W-1:0]            key_text    [lkec_pkg::CAPACITY];
    logic [lkec_pkg::SIZE_W-1:0]  key_size    [lkec_pkg::CAPACITY];
    logic [lkec_pkg::COLOR_W-1:0] shadow_rgba [lkec_pkg::CAPACITY];
    logic [lkec_pkg::STAMP_W-1:0] key_stamp   [lkec_pkg::CAPACITY];
    int                           filled = 0;
    logic [lkec_pkg::STAMP_W-1:0] tick = '0;

    // Key pool for the random part: clean text, length, overlong flag, size and color
    logic [TEXT_W-1:0]            pool_text  [POOL_MAX];
    int                           pool_len   [POOL_MAX];
    bit                           pool_long  [POOL_MAX];
    logic [lkec_pkg::SIZE_W-1:0]  pool_size  [POOL_MAX];
    logic [lkec_pkg::COLOR_W-1:0] pool_color [POOL_MAX];

    t_lookup_rsp expected_results [$];
    bit          idle_off = 0;
    int          stall_left = 0;
    int          err_count = 0;
    int          items_sent = 0;
    int          flushes_sent = 0;
    int          results_checked = 0;
    int          hits_seen = 0;
    int          evictions_seen = 0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Zero every byte after the first zero byte of the 15-byte string
    function automatic logic [TEXT_W-1:0] strip_padding(logic [TEXT_W-1:0] raw);
        logic [TEXT_W-1:0] txt;
        bit                ended;
        txt = raw;
        ended = 0;
        for (int b = 0; b < lkec_pkg::TEXT_BYTES; b++) begin
            if (ended) begin
                txt[b*8 +: 8] = 8'h00;
            end else if (txt[b*8 +: 8] == 8'h00) begin
                ended = 1;
            end
        end
        return txt;
    endfunction

    // Advance the shadow table by one item and return its result
    function automatic t_lookup_rsp cache_predict(t_lookup_req rq);
        t_lookup_rsp       rsp;
        logic [TEXT_W-1:0] txt;
        int                idx;
        bit                found;
        rsp = '0;
        if (rq.op == lkec_pkg::OP_FLUSH) begin
            filled = 0;
            return rsp;
        end
        txt = strip_padding({rq.text_hi, rq.text_lo});
        found = 0;
        idx = 0;
        if (!rq.too_long) begin
            for (int i = 0; i < filled; i++) begin
                if (!found && key_text[i] == txt && key_size[i] == rq.size &&
                    shadow_rgba[i] == rq.color) begin
                    found = 1;
                    idx = i;
                end
            end
        end
        if (!found) begin
            if (filled < lkec_pkg::CAPACITY) begin
                idx = filled;
                filled++;
            end else begin
                // oldest stamp goes, lowest index on a tie
                idx = 0;
                for (int i = 1; i < lkec_pkg::CAPACITY; i++) begin
                    if (key_stamp[i] < key_stamp[idx]) idx = i;
                end
                rsp.evicts = 1'b1;
            end
            key_text[idx]    = txt;
            key_size[idx]    = rq.size;
            shadow_rgba[idx] = rq.color;
        end
        tick = tick + 1'b1;
        key_stamp[idx] = tick;
        rsp.hit    = found;
        rsp.slot   = lkec_pkg::SLOT_W'(idx);
        rsp.in_use = lkec_pkg::COUNT_W'(filled);
        return rsp;
    endfunction

    function automatic t_lookup_req make_req(logic op, logic [lkec_pkg::TEXT_LO_W-1:0] lo,
                                             logic [lkec_pkg::TEXT_HI_W-1:0] hi,
                                             logic too_long,
                                             logic [lkec_pkg::SIZE_W-1:0] size,
                                             logic [lkec_pkg::COLOR_W-1:0] color);
        t_lookup_req rq;
        rq.op       = op;
        rq.text_lo  = lo;
        rq.text_hi  = hi;
        rq.too_long = too_long;
        rq.size     = size;
        rq.color    = color;
        return rq;
    endfunction

    task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
        err_count++;
        $display("tb: mismatch on %s at result %0d: expected %0d, got %0d",
                 what, results_checked, want, got);
    endtask

    // Drive one item, wait for its handshake, record its expected result
    task automatic send_item(t_lookup_req rq);
        int gap;
        if (!idle_off && $urandom_range(0, 2) == 0) begin
            gap = $urandom_range(1, 4);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.op            <= rq.op;
        in_ch.text_bytes_lo <= rq.text_lo;
        in_ch.text_bytes_hi <= rq.text_hi;
        in_ch.text_too_long <= rq.too_long;
        in_ch.pixel_size    <= rq.size;
        in_ch.pixel_color   <= rq.color;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
        if (rq.op == lkec_pkg::OP_FLUSH) flushes_sent++;
        expected_results.push_back(cache_predict(rq));
    endtask

    // Drop valid and hold until every expected result has come back
    task automatic wait_results_drained();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    // Fill the pool with n random keys, mostly well formed, a few overlong
    task automatic build_pool(int n);
        int len;
        for (int k = 0; k < n; k++) begin
            pool_long[k] = ($urandom_range(0, 15) == 0);
            len = pool_long[k] ? lkec_pkg::TEXT_BYTES : $urandom_range(0, lkec_pkg::TEXT_BYTES);
            pool_text[k] = '0;
            for (int b = 0; b < len; b++) pool_text[k][b*8 +: 8] = 8'($urandom_range(1, 255));
            pool_len[k]   = len;
            pool_size[k]  = lkec_pkg::SIZE_W'($urandom_range(0, 1023));
            pool_color[k] = $urandom;
        end
    endtask

    // Send one random item: a flush, raw noise, or a pool key with junk padding
    task automatic send_mixed(int pool_n, int noise_pct, int flush_one_in);
        t_lookup_req       rq;
        logic [TEXT_W-1:0] txt;
        int                k;
        if ($urandom_range(1, flush_one_in) == 1) begin
            rq = make_req(lkec_pkg::OP_FLUSH, {$urandom, $urandom},
                          lkec_pkg::TEXT_HI_W'({$urandom, $urandom}), 1'($urandom),
                          lkec_pkg::SIZE_W'($urandom), $urandom);
        end else if ($urandom_range(1, 100) <= noise_pct) begin
            rq = make_req(lkec_pkg::OP_LOOKUP, {$urandom, $urandom},
                          lkec_pkg::TEXT_HI_W'({$urandom, $urandom}), 1'($urandom),
                          lkec_pkg::SIZE_W'($urandom), $urandom);
        end else begin
            k = $urandom_range(0, pool_n - 1);
            txt = pool_text[k];
            for (int b = pool_len[k] + 1; b < lkec_pkg::TEXT_BYTES; b++) begin
                if ($urandom_range(0, 1) == 1) txt[b*8 +: 8] = 8'($urandom_range(0, 255));
            end
            rq = make_req(lkec_pkg::OP_LOOKUP, txt[lkec_pkg::TEXT_LO_W-1:0],
                          txt[TEXT_W-1:lkec_pkg::TEXT_LO_W],
                          pool_long[k], pool_size[k], pool_color[k]);
        end
        send_item(rq);
    endtask

    // Extremes, terminator padding, overlong strings and flushes
    task automatic test_directed_keys();
        send_item(make_req(lkec_pkg::OP_FLUSH, '0, '0, 1'b0, '0, '0));
        send_item(make_req(lkec_pkg::OP_LOOKUP, '1, '1, 1'b0, '1, '1));
        send_item(make_req(lkec_pkg::OP_LOOKUP, '1, '1, 1'b0, '1, '1));
        send_item(make_req(lkec_pkg::OP_LOOKUP, '1, '1, 1'b0, 10'h3FE, '1));
        send_item(make_req(lkec_pkg::OP_LOOKUP, '1, '1, 1'b0, '1, 32'hFFFF_FFFE));
        // empty string, then the same with junk after the terminator
        send_item(make_req(lkec_pkg::OP_LOOKUP, '0, '0, 1'b0, '0, '0));
        send_item(make_req(lkec_pkg::OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FF00, '1, 1'b0, '0, '0));
        // short string with differing padding
        send_item(make_req(lkec_pkg::OP_LOOKUP, 64'hA5C3_7E11_0063_6261, 56'h5A, 1'b0,
                           10'h155, 32'h1122_3344));
        send_item(make_req(lkec_pkg::OP_LOOKUP, 64'h1234_5678_0063_6261,
                           56'hFF_0000_0000_0000, 1'b0, 10'h155, 32'h1122_3344));
        send_item(make_req(lkec_pkg::OP_LOOKUP, 64'h0000_0000_0063_6261, '0, 1'b0,
                           10'h155, 32'h1122_3344));
        // terminator in the upper word
        send_item(make_req(lkec_pkg::OP_LOOKUP, 64'h4847_4645_4443_4241,
                           56'hFFEE_004C_4B4A_49, 1'b0, 10'h2AA, 32'h8080_8080));
        send_item(make_req(lkec_pkg::OP_LOOKUP, 64'h4847_4645_4443_4241,
                           56'h0133_004C_4B4A_49, 1'b0, 10'h2AA, 32'h8080_8080));
        // overlong never hits, but its truncated tag can be hit later
        send_item(make_req(lkec_pkg::OP_LOOKUP, '1, '1, 1'b1, '1, '1));
        send_item(make_req(lkec_pkg::OP_LOOKUP, '1, '1, 1'b1, '1, '1));
        send_item(make_req(lkec_pkg::OP_LOOKUP, 64'h0102_0304_0506_0708,
                           56'h09_0A0B_0C0D_0E0F, 1'b1, 10'h001, 32'h0000_0001));
        send_item(make_req(lkec_pkg::OP_LOOKUP, 64'h0102_0304_0506_0708,
                           56'h09_0A0B_0C0D_0E0F, 1'b0, 10'h001, 32'h0000_0001));
        send_item(make_req(lkec_pkg::OP_LOOKUP, '1, '1, 1'b0, '1, '1));
        // flush empties the table; refill starts at slot zero
        send_item(make_req(lkec_pkg::OP_FLUSH, '1, '1, 1'b1, '1, '1));
        send_item(make_req(lkec_pkg::OP_LOOKUP, '1, '1, 1'b0, '1, '1));
        send_item(make_req(lkec_pkg::OP_LOOKUP, '1, '1, 1'b0, '1, '1));
        send_item(make_req(lkec_pkg::OP_FLUSH, '0, '0, 1'b0, '0, '0));
        send_item(make_req(lkec_pkg::OP_FLUSH, '0, '0, 1'b0, '0, '0));
        wait_results_drained();
    endtask

    // Small pool: mostly hits
    task automatic test_warm_hits();
        build_pool(48);
        for (int n = 0; n < 450; n++) send_mixed(48, 10, 100);
        wait_results_drained();
    endtask

    // Pool larger than the table: steady evictions, with stretches of no idling
    task automatic test_eviction_churn();
        build_pool(160);
        for (int n = 0; n < 900; n++) begin
            idle_off = ((n % 200) >= 150);
            send_mixed(160, 10, 400);
        end
        idle_off = 0;
        wait_results_drained();
    endtask

    // Back-to-back traffic with no idling on either side
    task automatic test_full_rate_tail();
        idle_off = 1;
        build_pool(120);
        for (int n = 0; n < 400; n++) send_mixed(120, 8, 300);
        wait_results_drained();
    endtask

    // Result ready with random stall bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            out_ch.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!idle_off && $urandom_range(0, 3) == 0) begin
            out_ch.ready <= 1'b0;
            stall_left <= $urandom_range(0, 3);
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Compare each result with the oldest expectation
    always @(posedge i_clk) begin
        t_lookup_rsp want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", 0, 1);
            end else begin
                want = expected_results.pop_front();
                if (out_ch.hit !== want.hit) report_mismatch("hit", want.hit, out_ch.hit);
                if (out_ch.slot !== want.slot) report_mismatch("slot", want.slot, out_ch.slot);
                if (out_ch.evicts !== want.evicts)
                    report_mismatch("evicts", want.evicts, out_ch.evicts);
                if (out_ch.entries_in_use !== want.in_use)
                    report_mismatch("entries_in_use", want.in_use, out_ch.entries_in_use);
            end
            results_checked++;
            if (out_ch.hit === 1'b1) hits_seen++;
            if (out_ch.evicts === 1'b1) evictions_seen++;
        end
    end

    // Main sequence
    initial begin
        i_rst_n             <= 1'b0;
        in_ch.valid         <= 1'b0;
        in_ch.op            <= lkec_pkg::OP_LOOKUP;
        in_ch.text_bytes_lo <= '0;
        in_ch.text_bytes_hi <= '0;
        in_ch.text_too_long <= 1'b0;
        in_ch.pixel_size    <= '0;
        in_ch.pixel_color   <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_keys();
        test_warm_hits();
        test_eviction_churn();
        test_full_rate_tail();

        // hold past the longest walk so a stray result would still be caught
        repeat (120) @(posedge i_clk);
        if (expected_results.size() != 0) report_mismatch("results missing", 0,
                                                          expected_results.size());
        $display("tb: %0d items sent, %0d of them flushes; %0d results checked",
                 items_sent, flushes_sent, results_checked);
        $display("tb: %0d hits and %0d evictions seen", hits_seen, evictions_seen);
        if (err_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

    // Hang guard
    initial begin
        #10_000_000;
        $display("tb: done, errors");
        $finish;
    end

endmodule

/* sim.f */
hdl/lkec_pkg.sv
hdl/lkec_ifs.sv
hdl/lkec_ram.sv
hdl/lkec_ctrl.sv
hdl/lru_keyed_entry_cache.sv
tb/tb.sv
